>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define CMR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// property checked on every clock edge, reset included
`define CMR_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define CMR_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define CMR_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

>>> hw/rtl/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg
// shared constants, types and tables of the camera pose unit
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int NCFG             = 6;
  localparam int TABLE_LEN        = 24;

  // cordic datapath width, q2.30 with headroom
  localparam int CW = 34;

  localparam logic signed [CW-1:0] GAIN30    = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE30     = 34'sd1073741824;
  localparam logic signed [35:0]   PI30      = 36'sd3373259426;
  localparam logic signed [35:0]   TWO_PI30  = 36'sd6746518852;
  localparam logic signed [35:0]   HALF_PI30 = 36'sd1686629713;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_MOVE   = 2'd1;
  localparam logic [1:0] CMD_ROTATE = 2'd2;
  // unused code, pose returned unchanged
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_POS_X = 3'd0;
  localparam logic [2:0] REG_POS_Y = 3'd1;
  localparam logic [2:0] REG_POS_Z = 3'd2;
  localparam logic [2:0] REG_TGT_X = 3'd3;
  localparam logic [2:0] REG_TGT_Y = 3'd4;
  localparam logic [2:0] REG_TGT_Z = 3'd5;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cordic_res_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } sat_t;

  // arctangent of 2^-i in q2.30, truncated
  function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [CW-1:0] r;
    case (idx)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t r;
    if (v > 68'sd2147483647) begin
      r.hit = 1'b1;
      r.val = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r.hit = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.hit = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/cmr_in_if.sv
// ----------------------------------------------------------------------------
// cmr_in_if
// command channel of the camera pose unit
// ----------------------------------------------------------------------------
interface cmr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] speed;
  logic signed [19:0] angle;
  logic signed [17:0] axis_x;
  logic signed [17:0] axis_y;
  logic signed [17:0] axis_z;

  modport source (output valid, command, speed, angle, axis_x, axis_y, axis_z,
                  input ready);
  modport sink   (input valid, command, speed, angle, axis_x, axis_y, axis_z,
                  output ready);
endinterface

>>> hw/rtl/cmr_out_if.sv
// ----------------------------------------------------------------------------
// cmr_out_if
// pose result channel of the camera pose unit
// ----------------------------------------------------------------------------
interface cmr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_tgt_x;
  logic signed [31:0] out_tgt_y;
  logic signed [31:0] out_tgt_z;
  logic               saturated;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                  out_tgt_x, out_tgt_y, out_tgt_z, saturated, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z,
                  out_tgt_x, out_tgt_y, out_tgt_z, saturated, output ready);
endinterface

>>> hw/rtl/cmr_cordic.sv
// ----------------------------------------------------------------------------
// cmr_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module cmr_cordic #(
  parameter int STEPS = cmr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [cmr_pkg::CW-1:0]     z0,
  output cmr_pkg::cordic_res_t              res
);

  localparam int CNTW = $clog2(STEPS + 1);

  logic                          busy;
  logic                          done;
  logic [CNTW-1:0]               cnt;
  logic signed [cmr_pkg::CW-1:0] x;
  logic signed [cmr_pkg::CW-1:0] y;
  logic signed [cmr_pkg::CW-1:0] z;
  logic signed [cmr_pkg::CW-1:0] dx;
  logic signed [cmr_pkg::CW-1:0] dy;
  logic signed [cmr_pkg::CW-1:0] at;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = cmr_pkg::atan_entry(5'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= cmr_pkg::GAIN30;
      y <= '0;
      z <= z0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  assign res.done = done;
  assign res.x    = x;
  assign res.y    = y;

endmodule

>>> hw/rtl/camera_move_rotate.sv
// ----------------------------------------------------------------------------
// camera_move_rotate
// camera pose unit: load, move along view and rotate view about an axis
// ----------------------------------------------------------------------------
// The unit holds a camera position and look-at target (signed fixed point,
// FRAC_BITS fraction bits) and takes one command transaction at a time;
// every command returns one pose transaction. Move puts two products through
// the shared multiplier. Rotate runs a restoring angle reduction (one step
// per cycle), the cordic micro-rotations, then 24 products of the axis-angle
// matrix and the view-vector product through one shared 34x34 multiplier,
// one per cycle. in_ch.ready is high only while no command is in work; a
// finished pose waits in the output register, and the next command is
// taken meanwhile. Start pose registers sit on the APB port at byte offset
// 4*index.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_move_rotate #(
  parameter int FRAC_BITS    = cmr_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = cmr_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cmr_in_if.sink       in_ch,
  cmr_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // angle in q2.30 and its reduction by 2*pi
  localparam int ANG_W     = 50 - FRAC_BITS;
  localparam int RED_STEPS = (ANG_W > 33) ? ANG_W - 32 : 1;
  localparam int RW        = ANG_W + RED_STEPS + 1;
  localparam int RCW       = $clog2(RED_STEPS + 1);
  localparam int MW        = 34;
  localparam int PW        = 68;
  localparam int CW        = cmr_pkg::CW;

  localparam logic [4:0] STEP_LAST = 5'd24;
  localparam logic [35:0] TWO_PI_EXT = cmr_pkg::TWO_PI30;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MOD    = 9'b000000010,
    ST_WRAP   = 9'b000000100,
    ST_HALF   = 9'b000001000,
    ST_CORDIC = 9'b000010000,
    ST_MUL    = 9'b000100000,
    ST_FINAL  = 9'b001000000,
    ST_MOVE   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [31:0] cfg [cmr_pkg::NCFG];
  logic [2:0]         cfg_idx;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (cfg_idx < 3'(cmr_pkg::NCFG)) begin
      prdata = cfg[cfg_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[cmr_pkg::REG_POS_X] <= '0;
      cfg[cmr_pkg::REG_POS_Y] <= '0;
      cfg[cmr_pkg::REG_POS_Z] <= '0;
      cfg[cmr_pkg::REG_TGT_X] <= '0;
      cfg[cmr_pkg::REG_TGT_Y] <= 32'(64'sd1 <<< FRAC_BITS);
      cfg[cmr_pkg::REG_TGT_Z] <= 32'(64'sd1 <<< (FRAC_BITS - 1));
    end else if (psel && penable && pwrite && pready &&
                 cfg_idx < 3'(cmr_pkg::NCFG)) begin
      cfg[cfg_idx] <= pwdata;
    end
  end

  // pose and working registers
  logic signed [31:0]   pos [3];
  logic signed [31:0]   tgt [3];
  logic signed [MW-1:0] v [3];
  logic signed [31:0]   axq [3];
  logic signed [MW-1:0] p [6];
  logic signed [MW-1:0] t [6];
  logic signed [MW-1:0] sc [3];
  logic signed [PW-1:0] acc [3];
  logic signed [31:0]   speed;
  logic                 sat_flag;
  logic [RW-1:0]        rem;
  logic                 ang_neg;
  logic [RCW-1:0]       rcnt;
  logic signed [35:0]   ang;
  logic                 sc_neg;
  logic signed [CW-1:0] cs;
  logic signed [CW-1:0] sn;
  logic signed [CW-1:0] omc;
  logic [4:0]           step;
  logic signed [PW-1:0] prod;
  logic                 out_valid;
  logic                 cordic_start;
  logic signed [CW-1:0] cordic_z0;
  cmr_pkg::cordic_res_t cordic_res;

  logic in_accept;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  // axis component clamped to +-1.0 and moved to q2.30
  function automatic logic signed [31:0] axis_q30(input logic signed [17:0] raw);
    logic signed [31:0] w;
    logic signed [31:0] one;
    w   = 32'(raw);
    one = 32'(64'sd1 <<< FRAC_BITS);
    if (w > one) w = one;
    if (w < -one) w = -one;
    return w <<< (30 - FRAC_BITS);
  endfunction

  // angle as q2.30, then its magnitude for the reduction
  logic signed [ANG_W-1:0] ang30;
  logic signed [RW-1:0]    ang30_ext;
  assign ang30     = ANG_W'({in_ch.angle, {(30 - FRAC_BITS){1'b0}}});
  assign ang30_ext = RW'(ang30);

  logic [RW-1:0] red_sub;
  assign red_sub = RW'(TWO_PI_EXT) << (rcnt - 1'b1);

  // shared multiplier operand select
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [MW-1:0] m_sum;
  logic signed [MW-1:0] m_rnd;

  always_comb begin
    case (step)
      5'd15:   m_sum = cs + t[0];
      5'd16:   m_sum = t[3] - sc[2];
      5'd17:   m_sum = t[4] + sc[1];
      5'd18:   m_sum = t[3] + sc[2];
      5'd19:   m_sum = cs + t[1];
      5'd20:   m_sum = t[5] - sc[0];
      5'd21:   m_sum = t[4] - sc[1];
      5'd22:   m_sum = t[5] + sc[0];
      5'd23:   m_sum = cs + t[2];
      default: m_sum = '0;
    endcase
    m_rnd = (m_sum + MW'(8)) >>> 4;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MOVE) begin
      mul_a = (step == 5'd0) ? v[0] : v[2];
      mul_b = MW'(speed);
    end else begin
      case (step)
        5'd0:  begin mul_a = MW'(axq[0]); mul_b = MW'(axq[0]); end
        5'd1:  begin mul_a = MW'(axq[1]); mul_b = MW'(axq[1]); end
        5'd2:  begin mul_a = MW'(axq[2]); mul_b = MW'(axq[2]); end
        5'd3:  begin mul_a = MW'(axq[0]); mul_b = MW'(axq[1]); end
        5'd4:  begin mul_a = MW'(axq[0]); mul_b = MW'(axq[2]); end
        5'd5:  begin mul_a = MW'(axq[1]); mul_b = MW'(axq[2]); end
        5'd6:  begin mul_a = omc; mul_b = p[0]; end
        5'd7:  begin mul_a = omc; mul_b = p[1]; end
        5'd8:  begin mul_a = omc; mul_b = p[2]; end
        5'd9:  begin mul_a = omc; mul_b = p[3]; end
        5'd10: begin mul_a = omc; mul_b = p[4]; end
        5'd11: begin mul_a = omc; mul_b = p[5]; end
        5'd12: begin mul_a = MW'(axq[0]); mul_b = sn; end
        5'd13: begin mul_a = MW'(axq[1]); mul_b = sn; end
        5'd14: begin mul_a = MW'(axq[2]); mul_b = sn; end
        5'd15, 5'd18, 5'd21: begin mul_a = m_rnd; mul_b = v[0]; end
        5'd16, 5'd19, 5'd22: begin mul_a = m_rnd; mul_b = v[1]; end
        5'd17, 5'd20, 5'd23: begin mul_a = m_rnd; mul_b = v[2]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // product rounded back to q2.30, and the move delta
  logic signed [PW-1:0] prod_r30;
  logic signed [MW-1:0] rnd30;
  logic signed [PW-1:0] move_d;
  assign prod_r30 = (prod + (PW'(1) <<< 29)) >>> 30;
  assign rnd30    = prod_r30[MW-1:0];
  assign move_d   = (prod + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  // saturating updates
  cmr_pkg::sat_t mv_pos;
  cmr_pkg::sat_t mv_tgt;
  cmr_pkg::sat_t rot [3];
  logic [1:0]    mv_k;
  assign mv_k   = (step == 5'd1) ? 2'd0 : 2'd2;
  assign mv_pos = cmr_pkg::sat32(PW'(pos[mv_k]) + move_d);
  assign mv_tgt = cmr_pkg::sat32(PW'(tgt[mv_k]) + move_d);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rot[i] = cmr_pkg::sat32(PW'(pos[i]) + ((acc[i] + (PW'(1) <<< 25)) >>> 26));
    end
  end

  // angle folding into (-pi, pi]
  logic signed [35:0] ang_wrap;
  always_comb begin
    ang_wrap = ang;
    if (ang > cmr_pkg::PI30) begin
      ang_wrap = ang - cmr_pkg::TWO_PI30;
    end else if (ang <= -cmr_pkg::PI30) begin
      ang_wrap = ang + cmr_pkg::TWO_PI30;
    end
  end

  cmr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .z0    (cordic_z0),
    .res   (cordic_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      cordic_start <= 1'b0;
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
      tgt[0] <= '0;
      tgt[1] <= 32'(64'sd1 <<< FRAC_BITS);
      tgt[2] <= 32'(64'sd1 <<< (FRAC_BITS - 1));
    end else begin
      cordic_start <= 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            speed    <= in_ch.speed;
            sat_flag <= 1'b0;
            axq[0]   <= axis_q30(in_ch.axis_x);
            axq[1]   <= axis_q30(in_ch.axis_y);
            axq[2]   <= axis_q30(in_ch.axis_z);
            for (int i = 0; i < 3; i++) begin
              v[i] <= MW'(tgt[i]) - MW'(pos[i]);
            end
            ang_neg <= ang30 < 0;
            rem     <= (ang30 < 0) ? RW'(-ang30_ext) : RW'(ang30_ext);
            rcnt    <= RCW'(RED_STEPS);
            step    <= '0;
            case (in_ch.command)
              cmr_pkg::CMD_LOAD: begin
                pos[0] <= cfg[cmr_pkg::REG_POS_X];
                pos[1] <= cfg[cmr_pkg::REG_POS_Y];
                pos[2] <= cfg[cmr_pkg::REG_POS_Z];
                tgt[0] <= cfg[cmr_pkg::REG_TGT_X];
                tgt[1] <= cfg[cmr_pkg::REG_TGT_Y];
                tgt[2] <= cfg[cmr_pkg::REG_TGT_Z];
                state  <= ST_DONE;
              end
              cmr_pkg::CMD_MOVE:   state <= ST_MOVE;
              cmr_pkg::CMD_ROTATE: state <= ST_MOD;
              default:             state <= ST_DONE;
            endcase
          end
        end
        ST_MOD: begin
          // restoring reduction, one shifted 2*pi per cycle
          if (rem >= red_sub) begin
            rem <= rem - red_sub;
          end
          rcnt <= rcnt - 1'b1;
          if (rcnt == RCW'(1)) begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          ang   <= ang_neg ? -$signed(36'(rem)) : $signed(36'(rem));
          state <= ST_HALF;
        end
        ST_HALF: begin
          sc_neg       <= 1'b0;
          cordic_z0    <= CW'(ang_wrap);
          if (ang_wrap > cmr_pkg::HALF_PI30) begin
            cordic_z0 <= CW'(ang_wrap - cmr_pkg::PI30);
            sc_neg    <= 1'b1;
          end else if (ang_wrap < -cmr_pkg::HALF_PI30) begin
            cordic_z0 <= CW'(ang_wrap + cmr_pkg::PI30);
            sc_neg    <= 1'b1;
          end
          cordic_start <= 1'b1;
          state        <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (cordic_res.done) begin
            cs  <= sc_neg ? -cordic_res.x : cordic_res.x;
            sn  <= sc_neg ? -cordic_res.y : cordic_res.y;
            omc <= cmr_pkg::ONE30 - (sc_neg ? -cordic_res.x : cordic_res.x);
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            step   <= '0;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          // issue product of this step, retire the one of the step before
          if (step != STEP_LAST) begin
            prod <= mul_a * mul_b;
          end
          step <= step + 1'b1;
          case (step)
            5'd1:  p[0]  <= rnd30;
            5'd2:  p[1]  <= rnd30;
            5'd3:  p[2]  <= rnd30;
            5'd4:  p[3]  <= rnd30;
            5'd5:  p[4]  <= rnd30;
            5'd6:  p[5]  <= rnd30;
            5'd7:  t[0]  <= rnd30;
            5'd8:  t[1]  <= rnd30;
            5'd9:  t[2]  <= rnd30;
            5'd10: t[3]  <= rnd30;
            5'd11: t[4]  <= rnd30;
            5'd12: t[5]  <= rnd30;
            5'd13: sc[0] <= rnd30;
            5'd14: sc[1] <= rnd30;
            5'd15: sc[2] <= rnd30;
            5'd16, 5'd17, 5'd18: acc[0] <= acc[0] + prod;
            5'd19, 5'd20, 5'd21: acc[1] <= acc[1] + prod;
            5'd22, 5'd23, 5'd24: acc[2] <= acc[2] + prod;
            default: ;
          endcase
          if (step == STEP_LAST) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 3; i++) begin
            tgt[i] <= rot[i].val;
          end
          sat_flag <= rot[0].hit | rot[1].hit | rot[2].hit;
          state    <= ST_DONE;
        end
        ST_MOVE: begin
          if (step != 5'd2) begin
            prod <= mul_a * mul_b;
          end
          step <= step + 1'b1;
          if (step != 5'd0) begin
            pos[mv_k] <= mv_pos.val;
            tgt[mv_k] <= mv_tgt.val;
            if (mv_pos.hit || mv_tgt.hit) begin
              sat_flag <= 1'b1;
            end
          end
          if (step == 5'd2) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand the pose to the output register once it is free
          if (!out_valid || out_ch.ready) begin
            out_valid        <= 1'b1;
            out_ch.out_pos_x <= pos[0];
            out_ch.out_pos_y <= pos[1];
            out_ch.out_pos_z <= pos[2];
            out_ch.out_tgt_x <= tgt[0];
            out_ch.out_tgt_y <= tgt[1];
            out_ch.out_tgt_z <= tgt[2];
            out_ch.saturated <= sat_flag;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;

  // a taken command keeps the unit busy in the following cycle
  `CMR_ASSERT(a_busy_after_accept, clk, rst, in_accept |=> !in_ch.ready,
              "command channel ready right after a transaction")
  // a new result only appears from the hand-over state
  `CMR_ASSERT(a_result_source, clk, rst,
              $rose(out_ch.valid) |-> $past(state == ST_DONE),
              "result appeared outside hand-over")
  // cordic completion moves the sequencer on to the products
  `CMR_ASSERT(a_cordic_to_mul, clk, rst,
              (state == ST_CORDIC && cordic_res.done) |=> state == ST_MUL,
              "cordic result not taken")

endmodule

>>> tb/tb_camera_move_rotate.sv
// ----------------------------------------------------------------------------
// tb_camera_move_rotate
// self-checking bench for the camera pose unit
// ----------------------------------------------------------------------------
// A scoreboard class tracks the camera pose and the start pose registers. It
// predicts the pose for every accepted command transaction and compares
// every pose transaction with the oldest prediction. Stimulus is a directed
// list, then random commands over four idle/stall phases, with the start
// pose registers rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_camera_move_rotate;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] speed;
    logic signed [19:0] angle;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
  } cam_cmd_t;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] tgt [3];
    logic               sat;
  } cam_pose_t;

  class pose_scoreboard;
    localparam wide_t ONE_Q30  = 128'sd1073741824;
    localparam wide_t PI_Q30   = 128'sd3373259426;
    localparam wide_t TWOPI_Q30 = 128'sd6746518852;
    localparam wide_t HPI_Q30  = 128'sd1686629713;
    localparam wide_t K_Q30    = 128'sd652032874;

    logic signed [31:0] start_reg [6];
    logic signed [31:0] pos [3];
    logic signed [31:0] tgt [3];
    cam_pose_t          pending_poses [$];
    int                 errors;
    longint             arctan_q30 [16];

    function new();
      arctan_q30 = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                     64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                     64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                     64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
      start_reg = '{0, 0, 0, 0, 32'sd65536, 32'sd32768};
      for (int i = 0; i < 3; i++) begin
        pos[i] = start_reg[i];
        tgt[i] = start_reg[3 + i];
      end
      errors = 0;
    endfunction

    function void set_reg(int idx, logic signed [31:0] v);
      start_reg[idx] = v;
    endfunction

    // round to nearest, ties toward plus infinity
    function wide_t rnd_shr(wide_t x, int s);
      return (x + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function wide_t mul_q30(wide_t a, wide_t b);
      return rnd_shr(a * b, 30);
    endfunction

    function logic signed [31:0] clamp32(wide_t v, inout bit hit);
      if (v > 128'sd2147483647) begin
        hit = 1;
        return 32'sh7FFFFFFF;
      end
      if (v < -128'sd2147483648) begin
        hit = 1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    function void sin_cos(wide_t a_in, output wide_t c, output wide_t s);
      wide_t a, x, y, z, dx, dy;
      bit neg;
      neg = 0;
      a = a_in % TWOPI_Q30;
      if (a > PI_Q30) a = a - TWOPI_Q30;
      if (a <= -PI_Q30) a = a + TWOPI_Q30;
      if (a > HPI_Q30) begin
        a = a - PI_Q30;
        neg = 1;
      end else if (a < -HPI_Q30) begin
        a = a + PI_Q30;
        neg = 1;
      end
      x = K_Q30;
      y = 0;
      z = a;
      for (int i = 0; i < cmr_pkg::CORDIC_STEPS_DEF; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - wide_t'(arctan_q30[i]);
        end else begin
          x = x + dx; y = y - dy; z = z + wide_t'(arctan_q30[i]);
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function wide_t axis_q30(logic signed [17:0] raw);
      wide_t v;
      v = wide_t'(raw);
      if (v > 65536) v = 65536;
      if (v < -65536) v = -65536;
      return v <<< 14;
    endfunction

    function void rotate_view(cam_cmd_t c, inout bit hit);
      wide_t ax, ay, az, co, si, omc, acc;
      wide_t m [3][3];
      wide_t v [3];
      ax = axis_q30(c.ax);
      ay = axis_q30(c.ay);
      az = axis_q30(c.az);
      sin_cos(wide_t'(c.angle) <<< 14, co, si);
      omc = ONE_Q30 - co;
      m[0][0] = co + mul_q30(omc, mul_q30(ax, ax));
      m[1][1] = co + mul_q30(omc, mul_q30(ay, ay));
      m[2][2] = co + mul_q30(omc, mul_q30(az, az));
      m[0][1] = mul_q30(omc, mul_q30(ax, ay)) - mul_q30(az, si);
      m[1][0] = mul_q30(omc, mul_q30(ax, ay)) + mul_q30(az, si);
      m[0][2] = mul_q30(omc, mul_q30(ax, az)) + mul_q30(ay, si);
      m[2][0] = mul_q30(omc, mul_q30(ax, az)) - mul_q30(ay, si);
      m[1][2] = mul_q30(omc, mul_q30(ay, az)) - mul_q30(ax, si);
      m[2][1] = mul_q30(omc, mul_q30(ay, az)) + mul_q30(ax, si);
      for (int i = 0; i < 3; i++) v[i] = wide_t'(tgt[i]) - wide_t'(pos[i]);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc = acc + rnd_shr(m[i][j], 4) * v[j];
        tgt[i] = clamp32(wide_t'(pos[i]) + rnd_shr(acc, 26), hit);
      end
    endfunction

    function void note_command(cam_cmd_t c);
      cam_pose_t p;
      wide_t d;
      bit hit;
      hit = 0;
      case (c.cmd)
        cmr_pkg::CMD_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            pos[i] = start_reg[i];
            tgt[i] = start_reg[3 + i];
          end
        end
        cmr_pkg::CMD_MOVE: begin
          // y is left alone
          for (int k = 0; k < 3; k += 2) begin
            d = rnd_shr((wide_t'(tgt[k]) - wide_t'(pos[k])) * wide_t'(c.speed), 16);
            pos[k] = clamp32(wide_t'(pos[k]) + d, hit);
            tgt[k] = clamp32(wide_t'(tgt[k]) + d, hit);
          end
        end
        cmr_pkg::CMD_ROTATE: rotate_view(c, hit);
        default: ;
      endcase
      p.pos = pos;
      p.tgt = tgt;
      p.sat = hit;
      pending_poses.push_back(p);
    endfunction

    function void cmp(string name, logic signed [31:0] e, logic signed [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_pose(cam_pose_t got);
      cam_pose_t e;
      if (pending_poses.size() == 0) begin
        errors++;
        $display("%0t: unexpected pose transaction, expected none actual pos_x %0d",
                 $time, got.pos[0]);
        return;
      end
      e = pending_poses.pop_front();
      cmp("pos_x", e.pos[0], got.pos[0]);
      cmp("pos_y", e.pos[1], got.pos[1]);
      cmp("pos_z", e.pos[2], got.pos[2]);
      cmp("tgt_x", e.tgt[0], got.tgt[0]);
      cmp("tgt_y", e.tgt[1], got.tgt[1]);
      cmp("tgt_z", e.tgt[2], got.tgt[2]);
      if (e.sat !== got.sat) begin
        errors++;
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, got.sat);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 160;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cmr_in_if  cmd_ch ();
  cmr_out_if pose_ch ();

  pose_scoreboard sb;
  int sender_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  camera_move_rotate uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (pose_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = cmr_pkg::CMD_LOAD;
    cmd_ch.speed = '0; cmd_ch.angle = '0;
    cmd_ch.axis_x = '0; cmd_ch.axis_y = '0; cmd_ch.axis_z = '0;
    pose_ch.ready = 1'b1;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
  end

  // receiver back-pressure, changes on the falling edge
  always @(negedge clk) begin
    pose_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // input side monitor: feed each accepted command to the predictor
  always @(posedge clk) begin
    cam_cmd_t c;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c.cmd = cmd_ch.command;
      c.speed = cmd_ch.speed;
      c.angle = cmd_ch.angle;
      c.ax = cmd_ch.axis_x;
      c.ay = cmd_ch.axis_y;
      c.az = cmd_ch.axis_z;
      sb.note_command(c);
    end
  end

  // output side monitor
  always @(posedge clk) begin
    cam_pose_t p;
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      p.pos[0] = pose_ch.out_pos_x;
      p.pos[1] = pose_ch.out_pos_y;
      p.pos[2] = pose_ch.out_pos_z;
      p.tgt[0] = pose_ch.out_tgt_x;
      p.tgt[1] = pose_ch.out_tgt_y;
      p.tgt[2] = pose_ch.out_tgt_z;
      p.sat = pose_ch.saturated;
      sb.check_pose(p);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pose_ch.valid && pose_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one APB write: setup cycle, then access cycle
  task automatic apb_write(int idx, logic signed [31:0] v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 5'(idx * 4);
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // send one command transaction, with random idle cycles ahead of it
  task automatic send_cmd(cam_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.command = c.cmd;
    cmd_ch.speed = c.speed;
    cmd_ch.angle = c.angle;
    cmd_ch.axis_x = c.ax;
    cmd_ch.axis_y = c.ay;
    cmd_ch.axis_z = c.az;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (sb.pending_poses.size() > 0) @(posedge clk);
  endtask

  function automatic cam_cmd_t mk(logic [1:0] cmd, logic signed [31:0] sp,
                                  logic signed [19:0] an, logic signed [17:0] x,
                                  logic signed [17:0] y, logic signed [17:0] z);
    cam_cmd_t c;
    c.cmd = cmd; c.speed = sp; c.angle = an; c.ax = x; c.ay = y; c.az = z;
    return c;
  endfunction

  // mostly well-formed commands: unit axes, modest speeds, in-range angles
  function automatic cam_cmd_t random_cmd();
    cam_cmd_t c;
    int r;
    real vx, vy, vz, len;
    r = $urandom_range(99);
    c.cmd = (r < 8) ? cmr_pkg::CMD_LOAD : (r < 48) ? cmr_pkg::CMD_MOVE :
            (r < 94) ? cmr_pkg::CMD_ROTATE : cmr_pkg::CMD_UNUSED;
    if ($urandom_range(9) < 8) c.speed = $signed($urandom_range(196608)) - 98304;
    else c.speed = $urandom;
    if ($urandom_range(9) < 8) c.angle = 20'($signed($urandom_range(823550)) - 411775);
    else c.angle = 20'($urandom);
    if ($urandom_range(9) < 8) begin
      vx = $signed($urandom_range(2000)) - 1000.0;
      vy = $signed($urandom_range(2000)) - 1000.0;
      vz = $signed($urandom_range(2000)) - 1000.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      if (len < 1.0) begin
        vy = 1.0; len = 1.0;
      end
      c.ax = 18'($rtoi(vx / len * 65536.0));
      c.ay = 18'($rtoi(vy / len * 65536.0));
      c.az = 18'($rtoi(vz / len * 65536.0));
    end else begin
      // raw axis noise, out of range and non-unit included
      c.ax = 18'($urandom); c.ay = 18'($urandom); c.az = 18'($urandom);
    end
    return c;
  endfunction

  initial begin
    cam_cmd_t dir [$];
    #1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset pose, speed and angle extremes, axis corner cases
    dir.push_back(mk(cmr_pkg::CMD_LOAD, 0, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 0, 0, 18'sd65536, 0));
    dir.push_back(mk(cmr_pkg::CMD_MOVE, 32'sd65536, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_MOVE, -32'sd65536, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_MOVE, 32'sh7FFFFFFF, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_LOAD, 0, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_MOVE, 32'sh80000000, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_LOAD, 32'hFFFFFFFF, 20'hFFFFF, '1, '1, '1));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sd411775, 0, 18'sd65536, 0));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, -20'sd411775, 18'sd65536, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sd205887, 0, 0, -18'sd65536));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sd102944, -18'sd65536, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, -20'sd205887, 0, -18'sd65536, 0));
    // angle beyond two pi, both field extremes
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sh7FFFF, 0, 18'sd65536, 0));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sh80000, 0, 18'sd65536, 0));
    // axis beyond unit, clamped without flag
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sd51472, 18'sh1FFFF, 18'sh20000,
                     18'sh1FFFF));
    // non-unit axis
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sd30000, 18'sd65536, 18'sd65536,
                     18'sd65536));
    // unused command leaves the pose alone
    dir.push_back(mk(cmr_pkg::CMD_UNUSED, 32'h7FFFFFFF, 20'sh7FFFF, 18'sh1FFFF, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_MOVE, 32'sd3276800, 0, 0, 0, 0));
    dir.push_back(mk(cmr_pkg::CMD_ROTATE, 0, 20'sd70000, 0, 18'sd46341, 18'sd46341));
    foreach (dir[i]) send_cmd(dir[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      // start pose rewritten only while the unit is idle
      case (ph)
        1: begin
          for (int i = 0; i < 6; i++)
            apb_write(i, (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF);
        end
        2: begin
          for (int i = 0; i < 6; i++)
            apb_write(i, $signed($urandom_range(2097152)) - 1048576);
        end
        3: begin
          for (int i = 0; i < 6; i++) apb_write(i, $urandom);
        end
        default: begin
          for (int i = 0; i < 6; i++)
            apb_write(i, $signed($urandom_range(655360)) - 327680);
        end
      endcase
      sender_idle_pct = (ph == 1) ? 68 : (ph == 3) ? 31 : 0;
      recv_stall_pct  = (ph == 2) ? 68 : (ph == 3) ? 31 : 0;
      send_cmd(mk(cmr_pkg::CMD_LOAD, 0, 0, 0, 0, 0));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_cmd(random_cmd());
      drain();
      // extreme registers saturate quickly, pull them back before random work
      if (ph == 1) begin
        for (int i = 0; i < 6; i++) apb_write(i, (i == 4) ? 32'sd65536 : 32'sd0);
        send_cmd(mk(cmr_pkg::CMD_LOAD, 0, 0, 0, 0, 0));
        for (int n = 0; n < 20; n++) send_cmd(random_cmd());
        drain();
      end
    end

    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
